@@ rtl/wfisd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfisd_pkg: shared types and constants for the word filter / sorted dedup
// Field widths, register indexes, reset values and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package wfisd_pkg;

    // Default sizing
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_START_DEF   = 2;

    // Word geometry
    localparam int MAX_WORD     = 15;
    localparam int CHARS_LOW_W  = 64;
    localparam int CHARS_HIGH_W = 56;
    localparam int CHARS_W      = CHARS_LOW_W + CHARS_HIGH_W;
    localparam int LEN_IN_W     = 8;
    localparam int LEN_W        = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd1;

    localparam logic [LEN_W-1:0] MIN_LEN_RST = 4'd3;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 4'd15;

    // One table entry; bytes at or beyond the length are zero
    typedef struct packed {
        logic [CHARS_HIGH_W-1:0] chars_high;
        logic [CHARS_LOW_W-1:0]  chars_low;
        logic [LEN_W-1:0]        length;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic rd_en;      // read table entry into the read register
        logic wr_en;      // write table entry
        logic wr_new;     // write the held word (else the read register)
        logic load_word;  // capture the incoming word
        logic out_load;   // load the output register
        logic out_empty;  // output carries no word
        logic out_last;   // final beat of the run
        logic out_ovf;    // overflow flag to report
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cmp_lt;     // held word sorts before read entry
        logic cmp_eq;     // same key and length
    } t_status;

endpackage
`default_nettype wire

@@ rtl/wfisd_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfisd_in_if: input word channel
// Valid/ready channel carrying one word and its length per beat.
// ----------------------------------------------------------------------------
interface wfisd_in_if;
    logic                                valid;
    logic                                ready;
    logic [wfisd_pkg::CHARS_LOW_W-1:0]   word_chars_low;
    logic [wfisd_pkg::CHARS_HIGH_W-1:0]  word_chars_high;
    logic [wfisd_pkg::LEN_IN_W-1:0]      word_length;

    modport source (output valid, word_chars_low, word_chars_high, word_length,
                    input ready);
    modport sink   (input valid, word_chars_low, word_chars_high, word_length,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/wfisd_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfisd_out_if: sorted word output channel
// Valid/ready channel carrying one emitted word and its flags per beat.
// ----------------------------------------------------------------------------
interface wfisd_out_if;
    logic                                valid;
    logic                                ready;
    logic [wfisd_pkg::CHARS_LOW_W-1:0]   out_chars_low;
    logic [wfisd_pkg::CHARS_HIGH_W-1:0]  out_chars_high;
    logic [wfisd_pkg::LEN_W-1:0]         out_length;
    logic                                has_word;
    logic                                table_overflowed;
    logic                                last;

    modport source (output valid, out_chars_low, out_chars_high, out_length,
                    has_word, table_overflowed, last,
                    input ready);
    modport sink   (input valid, out_chars_low, out_chars_high, out_length,
                    has_word, table_overflowed, last,
                    output ready);
endinterface
`default_nettype wire

@@ rtl/word_filter_insertion_sort_dedup.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// word_filter_insertion_sort_dedup: length filter with sorted, unique table
// i_word carries one word (up to 15 bytes) and its length per beat. Words
// outside [min_length, max_length] are dropped; kept words go into a sorted
// table, duplicates (same key and length) dropped. A full table drops the
// word and sets a sticky overflow flag. A beat with length 0 ends the list:
// o_sorted gives every entry in order, last on the final beat, or one beat
// with has_word 0 for an empty table, and the table is emptied.
// i_cfg_we writes i_cfg_data to register i_cfg_index (0 = min_length,
// 1 = max_length); the user must do so only while the block is idle, as
// the block itself does not enforce it. One item at a time: i_word is
// closed while a word is scanned, shifted in or placed and while the
// table is emitted; a filtered word leaves the block idle. Emission reads
// each entry, then loads it; a stalled o_sorted holds the output register
// and pauses the walk. Reset clears the entry count and the overflow flag
// and restores the limits to 3 and 15.
// ----------------------------------------------------------------------------
module word_filter_insertion_sort_dedup #(
    parameter int TABLE_DEPTH = wfisd_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_START   = wfisd_pkg::KEY_START_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [wfisd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [wfisd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wfisd_in_if.sink                                i_word,
    wfisd_out_if.source                             o_sorted
);

    localparam int AW = $clog2(TABLE_DEPTH);

    wfisd_pkg::t_cmd    cmd;
    wfisd_pkg::t_status status;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               in_ready;
    logic               out_valid;

    assign i_word.ready   = in_ready;
    assign o_sorted.valid = out_valid;

    // Sequencer
    wfisd_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_word.valid),
        .o_in_ready  (in_ready),
        .i_in_length (i_word.word_length),
        .o_out_valid (out_valid),
        .i_out_ready (o_sorted.ready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_wr_addr   (wr_addr)
    );

    // Table and output datapath
    wfisd_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_START   (KEY_START)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_rd_addr    (rd_addr),
        .i_wr_addr    (wr_addr),
        .i_chars_low  (i_word.word_chars_low),
        .i_chars_high (i_word.word_chars_high),
        .i_length     (i_word.word_length),
        .o_status     (status),
        .o_chars_low  (o_sorted.out_chars_low),
        .o_chars_high (o_sorted.out_chars_high),
        .o_length     (o_sorted.out_length),
        .o_has_word   (o_sorted.has_word),
        .o_overflowed (o_sorted.table_overflowed),
        .o_last       (o_sorted.last)
    );

endmodule
`default_nettype wire

@@ rtl/wfisd_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfisd_dpath: table memory, word register, comparator and output register
// Holds the sorted table in a single-port-write, registered-read memory and
// compares the held word against the entry last read.
// ----------------------------------------------------------------------------
module wfisd_dpath #(
    parameter int TABLE_DEPTH = wfisd_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_START   = wfisd_pkg::KEY_START_DEF
) (
    input  wire logic                                i_clk,
    input  wire wfisd_pkg::t_cmd                     i_cmd,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]      i_rd_addr,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]      i_wr_addr,
    input  wire logic [wfisd_pkg::CHARS_LOW_W-1:0]   i_chars_low,
    input  wire logic [wfisd_pkg::CHARS_HIGH_W-1:0]  i_chars_high,
    input  wire logic [wfisd_pkg::LEN_IN_W-1:0]      i_length,
    output wfisd_pkg::t_status                       o_status,
    output logic [wfisd_pkg::CHARS_LOW_W-1:0]        o_chars_low,
    output logic [wfisd_pkg::CHARS_HIGH_W-1:0]       o_chars_high,
    output logic [wfisd_pkg::LEN_W-1:0]              o_length,
    output logic                                     o_has_word,
    output logic                                     o_overflowed,
    output logic                                     o_last
);

    localparam int KW = (wfisd_pkg::MAX_WORD - KEY_START) * 8;

    wfisd_pkg::t_entry r_mem [TABLE_DEPTH];
    wfisd_pkg::t_entry r_rd_data;
    wfisd_pkg::t_entry r_word;
    wfisd_pkg::t_entry n_word;

    logic [wfisd_pkg::CHARS_W-1:0] in_chars;
    logic [wfisd_pkg::CHARS_W-1:0] masked;
    logic [wfisd_pkg::CHARS_W-1:0] ca;
    logic [wfisd_pkg::CHARS_W-1:0] cb;
    logic [wfisd_pkg::LEN_W-1:0]   min_len;
    logic [KW-1:0]                 key_a;
    logic [KW-1:0]                 key_b;

    // Zero the bytes at and beyond the word length
    always_comb begin
        in_chars = {i_chars_high, i_chars_low};
        for (int p = 0; p < wfisd_pkg::MAX_WORD; p++) begin
            masked[8*p +: 8] = (wfisd_pkg::LEN_IN_W'(p) < i_length) ?
                               in_chars[8*p +: 8] : 8'h00;
        end
        n_word.chars_high = masked[wfisd_pkg::CHARS_W-1:wfisd_pkg::CHARS_LOW_W];
        n_word.chars_low  = masked[wfisd_pkg::CHARS_LOW_W-1:0];
        n_word.length     = i_length[wfisd_pkg::LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word) begin
            r_word <= n_word;
        end
    end

    // Table memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_cmd.wr_new ? r_word : r_rd_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Key compare: bytes from KEY_START over the shorter length, sign-flipped
    // so a plain unsigned compare orders them as signed chars
    always_comb begin
        ca      = {r_word.chars_high, r_word.chars_low};
        cb      = {r_rd_data.chars_high, r_rd_data.chars_low};
        min_len = (r_word.length < r_rd_data.length) ? r_word.length
                                                     : r_rd_data.length;
        for (int p = KEY_START; p < wfisd_pkg::MAX_WORD; p++) begin
            key_a[KW-1-8*(p-KEY_START) -: 8] = (wfisd_pkg::LEN_W'(p) < min_len) ?
                                               (ca[8*p +: 8] ^ 8'h80) : 8'h00;
            key_b[KW-1-8*(p-KEY_START) -: 8] = (wfisd_pkg::LEN_W'(p) < min_len) ?
                                               (cb[8*p +: 8] ^ 8'h80) : 8'h00;
        end
        o_status.cmp_lt = (key_a < key_b) ||
                          ((key_a == key_b) && (r_word.length < r_rd_data.length));
        o_status.cmp_eq = (key_a == key_b) && (r_word.length == r_rd_data.length);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_empty) begin
                o_chars_low  <= '0;
                o_chars_high <= '0;
                o_length     <= '0;
                o_has_word   <= 1'b0;
            end else begin
                o_chars_low  <= r_rd_data.chars_low;
                o_chars_high <= r_rd_data.chars_high;
                o_length     <= r_rd_data.length;
                o_has_word   <= 1'b1;
            end
            o_overflowed <= i_cmd.out_ovf;
            o_last       <= i_cmd.out_last;
        end
    end

endmodule
`default_nettype wire

@@ rtl/wfisd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wfisd_ctrl: sequencing state machine
// Filters lengths, scans the table for the insert point, shifts entries up,
// places the new word, and walks the table out at end of list.
// ----------------------------------------------------------------------------
module wfisd_ctrl #(
    parameter int TABLE_DEPTH = wfisd_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [wfisd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [wfisd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [wfisd_pkg::LEN_IN_W-1:0]     i_in_length,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    input  wire wfisd_pkg::t_status                 i_status,
    output wfisd_pkg::t_cmd                         o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]          o_rd_addr,
    output logic [$clog2(TABLE_DEPTH)-1:0]          o_wr_addr
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_INSERT = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_PLACE  = 3'd4;
    localparam logic [2:0] S_EM_RD  = 3'd5;
    localparam logic [2:0] S_EM_LD  = 3'd6;
    localparam logic [2:0] S_EMPTY  = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_ovf, n_ovf;
    logic [wfisd_pkg::LEN_W-1:0] r_min, n_min;
    logic [wfisd_pkg::LEN_W-1:0] r_max, n_max;
    logic [CW-1:0]               r_addr, n_addr;
    logic                        r_cmp_v, n_cmp_v;
    logic [CW-1:0]               r_pos, n_pos;
    logic [AW-1:0]               r_src, n_src;
    logic [AW-1:0]               r_wr_addr, n_wr_addr;
    logic                        r_wr_pend, n_wr_pend;
    logic                        r_rd_done, n_rd_done;
    logic                        r_out_valid, n_out_valid;

    logic len_ok;
    logic out_free;
    logic emit_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Configuration writes
    always_comb begin
        n_min = r_min;
        n_max = r_max;
        if (i_cfg_we) begin
            case (i_cfg_index)
                wfisd_pkg::REG_MIN_LENGTH: n_min = i_cfg_data;
                wfisd_pkg::REG_MAX_LENGTH: n_max = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_addr      = r_addr;
        n_cmp_v     = r_cmp_v;
        n_pos       = r_pos;
        n_src       = r_src;
        n_wr_addr   = r_wr_addr;
        n_wr_pend   = r_wr_pend;
        n_rd_done   = r_rd_done;
        o_cmd       = '0;
        o_cmd.out_ovf = r_ovf;
        o_rd_addr   = '0;
        o_wr_addr   = '0;

        len_ok = (i_in_length <= wfisd_pkg::LEN_IN_W'(wfisd_pkg::MAX_WORD)) &&
                 (i_in_length >= wfisd_pkg::LEN_IN_W'(r_min)) &&
                 (i_in_length <= wfisd_pkg::LEN_IN_W'(r_max));
        out_free  = !r_out_valid || i_out_ready;
        emit_last = ((CW'(r_src) + CW'(1)) == r_count);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_length == '0) begin
                        n_src   = '0;
                        n_state = (r_count == '0) ? S_EMPTY : S_EM_RD;
                    end else if (len_ok) begin
                        o_cmd.load_word = 1'b1;
                        n_addr  = '0;
                        n_cmp_v = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            // One entry read per cycle; the compare works on the registered read data
            S_SCAN: begin
                if (r_cmp_v && i_status.cmp_eq) begin
                    n_state = S_IDLE;
                end else if (r_cmp_v && i_status.cmp_lt) begin
                    n_pos   = r_addr - CW'(1);
                    n_state = S_INSERT;
                end else if (r_addr == r_count) begin
                    n_pos   = r_count;
                    n_state = S_INSERT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_addr[AW-1:0];
                    n_addr      = r_addr + CW'(1);
                    n_cmp_v     = 1'b1;
                end
            end
            S_INSERT: begin
                if (r_count == CW'(TABLE_DEPTH)) begin
                    n_ovf   = 1'b1;
                    n_state = S_IDLE;
                end else if (r_pos == r_count) begin
                    n_state = S_PLACE;
                end else begin
                    n_src     = AW'(r_count - CW'(1));
                    n_rd_done = 1'b0;
                    n_wr_pend = 1'b0;
                    n_state   = S_SHIFT;
                end
            end
            // Read entry j, write it to j+1 on the next cycle
            S_SHIFT: begin
                if (r_wr_pend) begin
                    o_cmd.wr_en = 1'b1;
                    o_wr_addr   = r_wr_addr;
                end
                if (!r_rd_done) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_src;
                    n_wr_addr   = r_src + AW'(1);
                    n_wr_pend   = 1'b1;
                    if (CW'(r_src) == r_pos) begin
                        n_rd_done = 1'b1;
                    end else begin
                        n_src = r_src - AW'(1);
                    end
                end else begin
                    n_wr_pend = 1'b0;
                    n_state   = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_new = 1'b1;
                o_wr_addr    = r_pos[AW-1:0];
                n_count      = r_count + CW'(1);
                n_state      = S_IDLE;
            end
            S_EM_RD: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = r_src;
                n_state     = S_EM_LD;
            end
            S_EM_LD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = emit_last;
                    if (emit_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_src   = r_src + AW'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            S_EMPTY: begin
                if (out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_empty = 1'b1;
                    o_cmd.out_last  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register occupancy
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_min       <= wfisd_pkg::MIN_LEN_RST;
            r_max       <= wfisd_pkg::MAX_LEN_RST;
            r_cmp_v     <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_rd_done   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_min       <= n_min;
            r_max       <= n_max;
            r_cmp_v     <= n_cmp_v;
            r_wr_pend   <= n_wr_pend;
            r_rd_done   <= n_rd_done;
            r_out_valid <= n_out_valid;
        end
    end

    // Addresses and indexes
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_pos     <= n_pos;
        r_src     <= n_src;
        r_wr_addr <= n_wr_addr;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared outside reset");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while stalled");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_cmd.wr_en)
        else $error("table write while idle");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && !r_rd_done) |-> (CW'(r_src) >= r_pos))
        else $error("shift source below insert point");
`endif

endmodule
`default_nettype wire
